// ===== design/fdgl_pkg.sv =====
`default_nettype none

package fdgl_pkg;

  // capacity defaults
  localparam int MAX_NODES_DEF = 32;
  localparam int MAX_EDGES_DEF = 64;

  // field widths
  localparam int POS_W     = 24;
  localparam int IDX_W     = 5;
  localparam int REP_W     = 16;
  localparam int REST_W    = 10;
  localparam int GAIN_W    = 16;
  localparam int SWEEPS_W  = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // datapath widths
  localparam int DIFF_W = POS_W + 1;          // position difference
  localparam int MAG_W  = POS_W;              // magnitude of a difference
  localparam int SQ_W   = 2 * MAG_W;          // one squared difference
  localparam int D2_W   = SQ_W + 1;           // squared distance
  localparam int REP_SH = 16;                 // repulsion numerator scale
  localparam int QUO_W  = MAG_W + REP_W;      // repulsion quotient
  localparam int NUM_W  = QUO_W + REP_SH;     // repulsion numerator

  // register reset values
  localparam int REPULSION_RST   = 250;
  localparam int REST_LENGTH_RST = 60;
  localparam int SPRING_GAIN_RST = 655;
  localparam int STEP_GAIN_RST   = 5243;
  localparam int SWEEPS_RST      = 50;

  typedef enum logic [1:0] {
    ACT_LOAD_NODE = 2'd0,
    ACT_LOAD_EDGE = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_RUN       = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPULSION   = 3'd0,
    REG_REST_LENGTH = 3'd1,
    REG_SPRING_GAIN = 3'd2,
    REG_STEP_GAIN   = 3'd3,
    REG_SWEEPS      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    action_t                   action;
    logic signed [POS_W-1:0]   start_x;
    logic signed [POS_W-1:0]   start_y;
    logic [IDX_W-1:0]          edge_a;
    logic [IDX_W-1:0]          edge_b;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]          node_index;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic                      last;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/fdgl_ram.sv =====
`default_nettype none

module fdgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/fdgl_div.sv =====
`default_nettype none

module fdgl_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [fdgl_pkg::NUM_W-1:0]  num,
  input  wire logic [fdgl_pkg::D2_W-1:0]   den,
  output logic      [fdgl_pkg::QUO_W-1:0]  quo,
  output logic                             done
);

  localparam int NW    = fdgl_pkg::NUM_W;
  localparam int DW    = fdgl_pkg::D2_W;
  localparam int QW    = fdgl_pkg::QUO_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem_r;
  logic [QW-1:0]    sh_r;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DW:0]      trial;
  logic             fits;

  // one quotient bit per cycle; the top numerator bits are below the divisor
  always_comb begin
    trial = {rem_r, sh_r[QW-1]};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(QW);
      rem_r  <= DW'(num[NW-1:QW]);
      sh_r   <= num[QW-1:0];
      den_r  <= den;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      sh_r  <= {sh_r[QW-2:0], fits};
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign quo  = sh_r;
  assign done = !busy_r;

endmodule

`default_nettype wire

// ===== design/force_directed_graph_layout.sv =====
`default_nettype none

// Force-directed layout engine. Node words (action load node) and edge words
// (action load edge) are taken one per cycle while idle into on-chip
// memories; words past MAX_NODES or MAX_EDGES are dropped, and clear resets
// both counts. A run word relaxes the nodes in place for the programmed number
// of sweeps and then returns one output word per node, in index order, with
// last on the final node; a run with no nodes returns nothing. A run is set by
// a sequencer around one node memory read port and two bit-serial dividers, for
// x and y in lockstep, and a bit-serial square root; each output word waits on
// out_ready. Configuration registers are to be written only while idle.
module force_directed_graph_layout #(
  parameter int MAX_NODES = fdgl_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = fdgl_pkg::MAX_EDGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire fdgl_pkg::in_word_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output fdgl_pkg::out_word_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [fdgl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fdgl_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int POS_W  = fdgl_pkg::POS_W;
  localparam int IDX_W  = fdgl_pkg::IDX_W;
  localparam int DIFF_W = fdgl_pkg::DIFF_W;
  localparam int MAG_W  = fdgl_pkg::MAG_W;
  localparam int SQ_W   = fdgl_pkg::SQ_W;
  localparam int D2_W   = fdgl_pkg::D2_W;
  localparam int QUO_W  = fdgl_pkg::QUO_W;
  localparam int REP_W  = fdgl_pkg::REP_W;
  localparam int REST_W = fdgl_pkg::REST_W;
  localparam int GAIN_W = fdgl_pkg::GAIN_W;
  localparam int SWP_W  = fdgl_pkg::SWEEPS_W;
  localparam int REP_SH = fdgl_pkg::REP_SH;

  localparam int NIW    = $clog2(MAX_NODES);
  localparam int NCW    = $clog2(MAX_NODES + 1);
  localparam int EIW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW    = $clog2(MAX_EDGES + 1);
  localparam int CMPW   = (NCW > IDX_W) ? NCW : IDX_W;
  localparam int NODE_W = 2 * POS_W;
  localparam int EDGE_W = 2 * IDX_W;

  localparam int ROOT_W = D2_W + 1;           // root iteration registers
  localparam int DIST_W = (D2_W + 1) / 2;     // integer root
  localparam int ST_W   = DIST_W + 2;         // signed stretch
  localparam int STM_W  = DIST_W + 1;         // stretch magnitude
  localparam int P1_W   = MAG_W + STM_W;
  localparam int T_W    = P1_W - 8;
  localparam int P2_W   = T_W + GAIN_W;
  localparam int F_W    = 52;                 // force sum
  localparam int FM_W   = 41;                 // clamped force magnitude
  localparam int P3_W   = FM_W + GAIN_W;
  localparam int NP_W   = FM_W + 2;           // new position before saturation

  localparam logic [D2_W-1:0]   D2_MIN   = D2_W'(1) << REP_SH;
  localparam logic [ROOT_W-1:0] ROOT_BIT = ROOT_W'(1) << (D2_W - 1);
  localparam logic [DIST_W-1:0] DIST_MIN = DIST_W'(256);
  localparam logic [FM_W-1:0]   F_LIM    = FM_W'(1) << (FM_W - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_NODE_RD, S_NODE_LD,
    S_REP_RD, S_REP_DIFF, S_REP_SQ, S_REP_SUM, S_REP_DIV,
    S_EDGE_RD, S_EDGE_CHK, S_SPR_DIFF, S_SPR_SQ, S_SPR_SUM, S_SQRT,
    S_SPR_ST, S_SPR_M1, S_SPR_M2, S_SPR_ACC,
    S_UPD_CLAMP, S_UPD_MUL, S_UPD_WR,
    S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  // magnitude of a position difference
  function automatic logic [MAG_W-1:0] diff_mag(input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] a;
    a = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return a[MAG_W-1:0];
  endfunction

  // signed force term from magnitude and sign
  function automatic logic signed [F_W-1:0] to_force(input logic [T_W-1:0] m,
                                                     input logic neg);
    logic signed [F_W-1:0] v;
    v = signed'({{(F_W-T_W){1'b0}}, m});
    return neg ? -v : v;
  endfunction

  // magnitude of a force sum, clamped
  function automatic logic [FM_W-1:0] force_mag(input logic signed [F_W-1:0] f);
    logic [F_W-1:0] a;
    a = f[F_W-1] ? F_W'(-f) : F_W'(f);
    return (a > {{(F_W-FM_W){1'b0}}, F_LIM}) ? F_LIM : a[FM_W-1:0];
  endfunction

  // position plus signed move, saturated
  function automatic logic [POS_W-1:0] move_pos(input logic signed [POS_W-1:0] p,
                                                input logic [FM_W-1:0] mv,
                                                input logic neg);
    logic signed [NP_W-1:0] pe, me, s, hi, lo;
    pe = {{(NP_W-POS_W){p[POS_W-1]}}, p};
    me = {{(NP_W-FM_W){1'b0}}, mv};
    s  = neg ? pe - me : pe + me;
    hi = {{(NP_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    lo = {{(NP_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
    if (s > hi) begin
      return hi[POS_W-1:0];
    end else if (s < lo) begin
      return lo[POS_W-1:0];
    end
    return s[POS_W-1:0];
  endfunction

  // configuration registers
  logic [REP_W-1:0]  repulsion_r;
  logic [REST_W-1:0] rest_r;
  logic [GAIN_W-1:0] spring_r;
  logic [GAIN_W-1:0] step_r;
  logic [SWP_W-1:0]  sweeps_r;

  // sequencer state
  state_t             state_r;
  logic [NCW-1:0]     node_cnt_r;
  logic [ECW-1:0]     edge_cnt_r;
  logic [NIW-1:0]     i_r;
  logic [NCW-1:0]     j_r;
  logic [ECW-1:0]     e_r;
  logic [NIW-1:0]     k_r;
  logic [SWP_W-1:0]   sweep_r;

  // datapath registers
  logic signed [POS_W-1:0]  xi_r, yi_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic [QUO_W-1:0]         numx_r, numy_r;
  logic signed [F_W-1:0]    fx_r, fy_r;
  logic [ROOT_W-1:0]        rt_v_r, rt_r_r, rt_bit_r;
  logic [STM_W-1:0]         stm_r;
  logic                     stneg_r;
  logic [T_W-1:0]           tx_r, ty_r, termx_r, termy_r;
  logic                     tnx_r, tny_r;
  logic [FM_W-1:0]          fmx_r, fmy_r, mvx_r, mvy_r;
  logic                     fnx_r, fny_r;
  fdgl_pkg::out_word_t      out_r;

  // memory ports
  logic              node_we;
  logic [NIW-1:0]    node_waddr, node_raddr;
  logic [NODE_W-1:0] node_wdata, node_rdata;
  logic              edge_we;
  logic [EDGE_W-1:0] edge_rdata;

  // combinational helpers
  logic                     load_node_ok, load_edge_ok;
  logic signed [POS_W-1:0]  rd_x, rd_y;
  logic signed [DIFF_W-1:0] xi_e, yi_e, rdx_e, rdy_e, diff_x, diff_y;
  logic [MAG_W-1:0]         mx, my;
  logic [D2_W-1:0]          d2, d2c;
  logic [IDX_W-1:0]         e_first, e_second, e_other;
  logic                     hit_f, hit_s, edge_use;
  logic [ROOT_W-1:0]        rt_sum;
  logic                     rt_ge;
  logic [DIST_W-1:0]        root_dist;
  logic signed [ST_W-1:0]   st;
  logic [P1_W-1:0]          p1x, p1y;
  logic [P2_W-1:0]          p2x, p2y;
  logic [P3_W-1:0]          p3x, p3y;
  logic [POS_W-1:0]         new_x, new_y;
  logic [QUO_W-1:0]         quo_x, quo_y;
  logic                     div_done_x, div_done_y, div_start;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repulsion_r <= REP_W'(fdgl_pkg::REPULSION_RST);
      rest_r      <= REST_W'(fdgl_pkg::REST_LENGTH_RST);
      spring_r    <= GAIN_W'(fdgl_pkg::SPRING_GAIN_RST);
      step_r      <= GAIN_W'(fdgl_pkg::STEP_GAIN_RST);
      sweeps_r    <= SWP_W'(fdgl_pkg::SWEEPS_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdgl_pkg::REG_REPULSION:   repulsion_r <= cfg_wdata[REP_W-1:0];
        fdgl_pkg::REG_REST_LENGTH: rest_r      <= cfg_wdata[REST_W-1:0];
        fdgl_pkg::REG_SPRING_GAIN: spring_r    <= cfg_wdata[GAIN_W-1:0];
        fdgl_pkg::REG_STEP_GAIN:   step_r      <= cfg_wdata[GAIN_W-1:0];
        fdgl_pkg::REG_SWEEPS:      sweeps_r    <= cfg_wdata[SWP_W-1:0];
        default: ;
      endcase
    end
  end

  // load gating
  always_comb begin
    load_node_ok = (state_r == S_IDLE) && in_valid &&
                   (in_data.action == fdgl_pkg::ACT_LOAD_NODE) &&
                   (node_cnt_r < NCW'(MAX_NODES));
    load_edge_ok = (state_r == S_IDLE) && in_valid &&
                   (in_data.action == fdgl_pkg::ACT_LOAD_EDGE) &&
                   (edge_cnt_r < ECW'(MAX_EDGES));
  end

  // differences against the node under update
  always_comb begin
    rd_x   = node_rdata[NODE_W-1:POS_W];
    rd_y   = node_rdata[POS_W-1:0];
    xi_e   = {xi_r[POS_W-1], xi_r};
    yi_e   = {yi_r[POS_W-1], yi_r};
    rdx_e  = {rd_x[POS_W-1], rd_x};
    rdy_e  = {rd_y[POS_W-1], rd_y};
    diff_x = (state_r == S_REP_DIFF) ? xi_e - rdx_e : rdx_e - xi_e;
    diff_y = (state_r == S_REP_DIFF) ? yi_e - rdy_e : rdy_e - yi_e;
    mx     = diff_mag(dx_r);
    my     = diff_mag(dy_r);
    d2     = D2_W'(sqx_r) + D2_W'(sqy_r);
    d2c    = (d2 < D2_MIN) ? D2_MIN : d2;
  end

  // edge endpoint match
  always_comb begin
    e_first  = edge_rdata[EDGE_W-1:IDX_W];
    e_second = edge_rdata[IDX_W-1:0];
    hit_f    = CMPW'(e_first) == CMPW'(i_r);
    hit_s    = CMPW'(e_second) == CMPW'(i_r);
    e_other  = hit_f ? e_second : e_first;
    edge_use = (hit_f || hit_s) && (CMPW'(e_other) < CMPW'(node_cnt_r));
  end

  // root step, spring stretch and products
  always_comb begin
    rt_sum    = rt_r_r + rt_bit_r;
    rt_ge     = rt_v_r >= rt_sum;
    root_dist = (rt_r_r[DIST_W-1:0] < DIST_MIN) ? DIST_MIN : rt_r_r[DIST_W-1:0];
    st        = signed'(ST_W'(root_dist)) - signed'(ST_W'({rest_r, 8'h00}));
    p1x       = P1_W'(mx) * P1_W'(stm_r);
    p1y       = P1_W'(my) * P1_W'(stm_r);
    p2x       = P2_W'(tx_r) * P2_W'(spring_r);
    p2y       = P2_W'(ty_r) * P2_W'(spring_r);
    p3x       = P3_W'(fmx_r) * P3_W'(step_r);
    p3y       = P3_W'(fmy_r) * P3_W'(step_r);
    new_x     = move_pos(xi_r, mvx_r, fnx_r);
    new_y     = move_pos(yi_r, mvy_r, fny_r);
  end

  // node memory addressing
  always_comb begin
    unique case (state_r)
      S_REP_RD:   node_raddr = j_r[NIW-1:0];
      S_EDGE_CHK: node_raddr = NIW'(e_other);
      S_OUT_RD:   node_raddr = k_r;
      default:    node_raddr = i_r;
    endcase
    node_we    = load_node_ok || (state_r == S_UPD_WR);
    node_waddr = (state_r == S_IDLE) ? node_cnt_r[NIW-1:0] : i_r;
    node_wdata = (state_r == S_IDLE) ? {in_data.start_x, in_data.start_y}
                                     : {new_x, new_y};
    edge_we    = load_edge_ok;
    div_start  = (state_r == S_REP_SUM);
  end

  fdgl_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  fdgl_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_cnt_r[EIW-1:0]),
    .wdata ({in_data.edge_a, in_data.edge_b}),
    .raddr (e_r[EIW-1:0]),
    .rdata (edge_rdata)
  );

  // repulsion quotients, x and y in lockstep
  fdgl_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({numx_r, {REP_SH{1'b0}}}),
    .den   (d2c),
    .quo   (quo_x),
    .done  (div_done_x)
  );

  fdgl_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({numy_r, {REP_SH{1'b0}}}),
    .den   (d2c),
    .quo   (quo_y),
    .done  (div_done_y)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      node_cnt_r <= '0;
      edge_cnt_r <= '0;
      i_r        <= '0;
      j_r        <= '0;
      e_r        <= '0;
      k_r        <= '0;
      sweep_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_data.action)
              fdgl_pkg::ACT_LOAD_NODE: begin
                if (load_node_ok) begin
                  node_cnt_r <= node_cnt_r + NCW'(1);
                end
              end
              fdgl_pkg::ACT_LOAD_EDGE: begin
                if (load_edge_ok) begin
                  edge_cnt_r <= edge_cnt_r + ECW'(1);
                end
              end
              fdgl_pkg::ACT_CLEAR: begin
                node_cnt_r <= '0;
                edge_cnt_r <= '0;
              end
              fdgl_pkg::ACT_RUN: begin
                if (node_cnt_r == '0) begin
                  state_r <= S_IDLE;
                end else if (sweeps_r == '0) begin
                  k_r     <= '0;
                  state_r <= S_OUT_RD;
                end else begin
                  i_r     <= '0;
                  sweep_r <= '0;
                  state_r <= S_NODE_RD;
                end
              end
            endcase
          end
        end
        S_NODE_RD: begin
          state_r <= S_NODE_LD;
        end
        S_NODE_LD: begin
          xi_r    <= rd_x;
          yi_r    <= rd_y;
          fx_r    <= '0;
          fy_r    <= '0;
          j_r     <= '0;
          state_r <= S_REP_RD;
        end
        // repulsion from every other node
        S_REP_RD: begin
          if (j_r == node_cnt_r) begin
            e_r     <= '0;
            state_r <= S_EDGE_RD;
          end else if (j_r == NCW'(i_r)) begin
            j_r <= j_r + NCW'(1);
          end else begin
            state_r <= S_REP_DIFF;
          end
        end
        S_REP_DIFF, S_SPR_DIFF: begin
          dx_r    <= diff_x;
          dy_r    <= diff_y;
          state_r <= (state_r == S_REP_DIFF) ? S_REP_SQ : S_SPR_SQ;
        end
        S_REP_SQ, S_SPR_SQ: begin
          sqx_r   <= SQ_W'(mx) * SQ_W'(mx);
          sqy_r   <= SQ_W'(my) * SQ_W'(my);
          numx_r  <= QUO_W'(mx) * QUO_W'(repulsion_r);
          numy_r  <= QUO_W'(my) * QUO_W'(repulsion_r);
          state_r <= (state_r == S_REP_SQ) ? S_REP_SUM : S_SPR_SUM;
        end
        S_REP_SUM: begin
          state_r <= S_REP_DIV;
        end
        S_REP_DIV: begin
          if (div_done_x) begin
            fx_r    <= fx_r + to_force(T_W'(quo_x), dx_r[DIFF_W-1]);
            fy_r    <= fy_r + to_force(T_W'(quo_y), dy_r[DIFF_W-1]);
            j_r     <= j_r + NCW'(1);
            state_r <= S_REP_RD;
          end
        end
        // springs on edges touching this node
        S_EDGE_RD: begin
          state_r <= (e_r == edge_cnt_r) ? S_UPD_CLAMP : S_EDGE_CHK;
        end
        S_EDGE_CHK: begin
          e_r     <= e_r + ECW'(1);
          state_r <= edge_use ? S_SPR_DIFF : S_EDGE_RD;
        end
        S_SPR_SUM: begin
          rt_v_r   <= ROOT_W'(d2);
          rt_r_r   <= '0;
          rt_bit_r <= ROOT_BIT;
          state_r  <= S_SQRT;
        end
        S_SQRT: begin
          rt_v_r   <= rt_ge ? rt_v_r - rt_sum : rt_v_r;
          rt_r_r   <= rt_ge ? (rt_r_r >> 1) + rt_bit_r : rt_r_r >> 1;
          rt_bit_r <= rt_bit_r >> 2;
          if (rt_bit_r[0]) begin
            state_r <= S_SPR_ST;
          end
        end
        S_SPR_ST: begin
          stneg_r <= st[ST_W-1];
          stm_r   <= st[ST_W-1] ? STM_W'(-st) : STM_W'(st);
          state_r <= S_SPR_M1;
        end
        S_SPR_M1: begin
          tx_r    <= p1x[P1_W-1:8];
          ty_r    <= p1y[P1_W-1:8];
          tnx_r   <= dx_r[DIFF_W-1] ^ stneg_r;
          tny_r   <= dy_r[DIFF_W-1] ^ stneg_r;
          state_r <= S_SPR_M2;
        end
        S_SPR_M2: begin
          termx_r <= p2x[P2_W-1:16];
          termy_r <= p2y[P2_W-1:16];
          state_r <= S_SPR_ACC;
        end
        S_SPR_ACC: begin
          fx_r    <= fx_r + to_force(termx_r, tnx_r);
          fy_r    <= fy_r + to_force(termy_r, tny_r);
          state_r <= S_EDGE_RD;
        end
        // move and write back
        S_UPD_CLAMP: begin
          fmx_r   <= force_mag(fx_r);
          fmy_r   <= force_mag(fy_r);
          fnx_r   <= fx_r[F_W-1];
          fny_r   <= fy_r[F_W-1];
          state_r <= S_UPD_MUL;
        end
        S_UPD_MUL: begin
          mvx_r   <= p3x[P3_W-1:16];
          mvy_r   <= p3y[P3_W-1:16];
          state_r <= S_UPD_WR;
        end
        S_UPD_WR: begin
          if (NCW'(i_r) + NCW'(1) == node_cnt_r) begin
            i_r <= '0;
            if ({1'b0, sweep_r} + (SWP_W+1)'(1) == {1'b0, sweeps_r}) begin
              k_r     <= '0;
              state_r <= S_OUT_RD;
            end else begin
              sweep_r <= sweep_r + SWP_W'(1);
              state_r <= S_NODE_RD;
            end
          end else begin
            i_r     <= i_r + NIW'(1);
            state_r <= S_NODE_RD;
          end
        end
        // final positions
        S_OUT_RD: begin
          state_r <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_r.node_index <= IDX_W'(k_r);
          out_r.pos_x      <= rd_x;
          out_r.pos_y      <= rd_y;
          out_r.last       <= (NCW'(k_r) + NCW'(1) == node_cnt_r);
          state_r          <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            if (out_r.last) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + NIW'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT_WAIT);
  assign out_data  = out_r;

  // checks
  a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while an output word is pending");

  a_node_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    node_cnt_r <= NCW'(MAX_NODES))
    else $error("node count beyond capacity");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_done_x == div_done_y)
    else $error("x and y dividers out of step");

  a_out_index_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (NCW'(k_r) < node_cnt_r))
    else $error("output index beyond node count");

  a_writeback_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD_WR) |=> (state_r == S_NODE_RD || state_r == S_OUT_RD))
    else $error("write-back not followed by next node or output");

endmodule

`default_nettype wire

// ===== tb/force_directed_graph_layout_test.sv =====
`timescale 1ns / 100ps

module force_directed_graph_layout_test;

  localparam int NODE_CAP = 32;
  localparam int EDGE_CAP = 64;
  localparam int POS_W = fdgl_pkg::POS_W;
  localparam int IDX_W = fdgl_pkg::IDX_W;
  localparam int CFG_W = fdgl_pkg::CFG_W;
  localparam longint POS_HI = 64'sd8388607;
  localparam longint POS_LO = -64'sd8388608;
  localparam longint FORCE_CAP = 64'sd1 << 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fdgl_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fdgl_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [fdgl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  force_directed_graph_layout i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // layout state mirrored in the testbench
  longint unsigned repulsion_m, rest_m, spring_m, step_m, sweeps_m;
  longint pos_x_m [NODE_CAP];
  longint pos_y_m [NODE_CAP];
  int edge_a_m [EDGE_CAP];
  int edge_b_m [EDGE_CAP];
  int nodes_m, edges_m;

  fdgl_pkg::in_word_t word_queue [$];
  fdgl_pkg::out_word_t final_positions [$];
  int words_queued, words_taken, mismatches;
  bit taken, idling_on;
  int tx_gap, rx_gap;

  initial forever #5 clk = ~clk;

  initial begin
    #200_000_000;
    $display("force_directed_graph_layout verification failed");
    $finish;
  end

  function automatic longint unsigned magnitude(longint a);
    return a < 0 ? longint'(-a) : longint'(a);
  endfunction

  // sign(a*b) * floor(|a*b| / 2^sh)
  function automatic longint scaled_product(longint a, longint b, int sh);
    longint unsigned m;
    m = (magnitude(a) * magnitude(b)) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint repel_term(longint d, longint unsigned d2);
    longint unsigned m;
    m = magnitude(d) * repulsion_m * 64'd65536 / d2;
    return d < 0 ? -longint'(m) : longint'(m);
  endfunction

  // one in-place node update
  function automatic void relax_node(int i);
    longint xi, yi, fx, fy, dx, dy, st;
    longint unsigned d2, root_dist;
    int other;
    xi = pos_x_m[i];
    yi = pos_y_m[i];
    fx = 0;
    fy = 0;
    for (int j = 0; j < nodes_m; j++) begin
      if (j == i) continue;
      dx = xi - pos_x_m[j];
      dy = yi - pos_y_m[j];
      d2 = longint'(dx * dx) + longint'(dy * dy);
      if (d2 < 65536) d2 = 65536;
      fx += repel_term(dx, d2);
      fy += repel_term(dy, d2);
    end
    for (int e = 0; e < edges_m; e++) begin
      if (edge_a_m[e] == i) other = edge_b_m[e];
      else if (edge_b_m[e] == i) other = edge_a_m[e];
      else continue;
      if (other >= nodes_m) continue;
      dx = pos_x_m[other] - xi;
      dy = pos_y_m[other] - yi;
      d2 = longint'(dx * dx) + longint'(dy * dy);
      root_dist = int_sqrt(d2);
      if (root_dist < 256) root_dist = 256;
      st = longint'(root_dist) - longint'(rest_m << 8);
      fx += scaled_product(scaled_product(dx, st, 8), longint'(spring_m), 16);
      fy += scaled_product(scaled_product(dy, st, 8), longint'(spring_m), 16);
    end
    fx = saturate(fx, -FORCE_CAP, FORCE_CAP);
    fy = saturate(fy, -FORCE_CAP, FORCE_CAP);
    pos_x_m[i] = saturate(xi + scaled_product(fx, longint'(step_m), 16), POS_LO, POS_HI);
    pos_y_m[i] = saturate(yi + scaled_product(fy, longint'(step_m), 16), POS_LO, POS_HI);
  endfunction

  // apply one accepted word and queue the positions a run returns
  function automatic void apply_layout_word(fdgl_pkg::in_word_t w);
    fdgl_pkg::out_word_t o;
    case (w.action)
      fdgl_pkg::ACT_LOAD_NODE: begin
        if (nodes_m < NODE_CAP) begin
          pos_x_m[nodes_m] = longint'(w.start_x);
          pos_y_m[nodes_m] = longint'(w.start_y);
          nodes_m++;
        end
      end
      fdgl_pkg::ACT_LOAD_EDGE: begin
        if (edges_m < EDGE_CAP) begin
          edge_a_m[edges_m] = w.edge_a;
          edge_b_m[edges_m] = w.edge_b;
          edges_m++;
        end
      end
      fdgl_pkg::ACT_CLEAR: begin
        nodes_m = 0;
        edges_m = 0;
      end
      default: begin
        for (longint unsigned s = 0; s < sweeps_m; s++)
          for (int i = 0; i < nodes_m; i++) relax_node(i);
        for (int i = 0; i < nodes_m; i++) begin
          o.node_index = i[IDX_W-1:0];
          o.pos_x = pos_x_m[i][POS_W-1:0];
          o.pos_y = pos_y_m[i][POS_W-1:0];
          o.last = (i + 1 == nodes_m);
          final_positions.push_back(o);
        end
      end
    endcase
  endfunction

  // input side: acceptance and prediction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      apply_layout_word(in_data);
      words_taken++;
      taken = 1'b1;
    end
  end

  // input side: driving
  always @(negedge clk) begin
    if (!in_valid || taken) begin
      taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (rst_n && word_queue.size() > 0) begin
        in_data <= word_queue.pop_front();
        in_valid <= 1'b1;
        if (idling_on && $urandom_range(0, 3) == 0) tx_gap = $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: stalls
  always @(negedge clk) begin
    if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idling_on && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 5);
    end
  end

  // result side: checking
  always @(posedge clk) begin
    fdgl_pkg::out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (final_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", out_data);
      end else begin
        exp_w = final_positions.pop_front();
        if (out_data.node_index !== exp_w.node_index || out_data.pos_x !== exp_w.pos_x ||
            out_data.pos_y !== exp_w.pos_y || out_data.last !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected idx %0d x %0d y %0d last %0b, ",
                      "got idx %0d x %0d y %0d last %0b"},
                     exp_w.node_index, exp_w.pos_x, exp_w.pos_y, exp_w.last,
                     out_data.node_index, out_data.pos_x, out_data.pos_y, out_data.last);
        end
      end
    end
  end

  task automatic send(fdgl_pkg::action_t a, longint x, longint y, int ea, int eb);
    fdgl_pkg::in_word_t w;
    w.action = a;
    w.start_x = x[POS_W-1:0];
    w.start_y = y[POS_W-1:0];
    w.edge_a = ea[IDX_W-1:0];
    w.edge_b = eb[IDX_W-1:0];
    word_queue.push_back(w);
    words_queued++;
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || final_positions.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(fdgl_pkg::cfg_reg_t r, int unsigned v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v[CFG_W-1:0];
    case (r)
      fdgl_pkg::REG_REPULSION:   repulsion_m = v & 16'hFFFF;
      fdgl_pkg::REG_REST_LENGTH: rest_m = v & 10'h3FF;
      fdgl_pkg::REG_SPRING_GAIN: spring_m = v & 16'hFFFF;
      fdgl_pkg::REG_STEP_GAIN:   step_m = v & 16'hFFFF;
      default:                   sweeps_m = v & 8'hFF;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int unsigned rep, int unsigned rest, int unsigned spr,
                          int unsigned stp, int unsigned swp);
    write_reg(fdgl_pkg::REG_REPULSION, rep);
    write_reg(fdgl_pkg::REG_REST_LENGTH, rest);
    write_reg(fdgl_pkg::REG_SPRING_GAIN, spr);
    write_reg(fdgl_pkg::REG_STEP_GAIN, stp);
    write_reg(fdgl_pkg::REG_SWEEPS, swp);
  endtask

  function automatic longint rand_pos();
    if ($urandom_range(0, 7) == 0)
      return longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
    return longint'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int unsigned rand_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 8000);
    endcase
  endfunction

  initial begin
    int n, e;
    repulsion_m = fdgl_pkg::REPULSION_RST;
    rest_m = fdgl_pkg::REST_LENGTH_RST;
    spring_m = fdgl_pkg::SPRING_GAIN_RST;
    step_m = fdgl_pkg::STEP_GAIN_RST;
    sweeps_m = fdgl_pkg::SWEEPS_RST;
    nodes_m = 0;
    edges_m = 0;
    idling_on = 1'b1;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, empty run, extremes, odd edges, repeated run
    send(fdgl_pkg::ACT_RUN, 0, 0, 0, 0);
    send(fdgl_pkg::ACT_LOAD_NODE, POS_HI, POS_LO, 0, 0);
    send(fdgl_pkg::ACT_LOAD_NODE, POS_LO, POS_HI, 0, 0);
    send(fdgl_pkg::ACT_LOAD_NODE, 0, 0, 0, 0);
    send(fdgl_pkg::ACT_LOAD_NODE, 0, 0, 0, 0);
    send(fdgl_pkg::ACT_LOAD_EDGE, 0, 0, 0, 1);
    send(fdgl_pkg::ACT_LOAD_EDGE, 0, 0, 2, 2);
    send(fdgl_pkg::ACT_LOAD_EDGE, 0, 0, 0, 31);
    send(fdgl_pkg::ACT_LOAD_EDGE, 0, 0, 3, 2);
    send(fdgl_pkg::ACT_RUN, 0, 0, 0, 0);
    send(fdgl_pkg::ACT_RUN, 0, 0, 0, 0);
    send(fdgl_pkg::ACT_CLEAR, 0, 0, 0, 0);
    send(fdgl_pkg::ACT_RUN, 0, 0, 0, 0);
    wait_idle();

    // zero sweeps only reports positions
    set_regs(1000, 10, 30000, 20000, 0);
    send(fdgl_pkg::ACT_LOAD_NODE, 256, -256, 0, 0);
    send(fdgl_pkg::ACT_LOAD_NODE, -5000, 77, 0, 0);
    send(fdgl_pkg::ACT_RUN, 0, 0, 0, 0);
    wait_idle();

    // full stores with extreme settings
    set_regs(65535, 1023, 65535, 65535, 1);
    send(fdgl_pkg::ACT_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < NODE_CAP + 2; i++)
      send(fdgl_pkg::ACT_LOAD_NODE, rand_pos(), rand_pos(), 0, 0);
    for (int i = 0; i < EDGE_CAP + 2; i++)
      send(fdgl_pkg::ACT_LOAD_EDGE, 0, 0, $urandom_range(0, 31), $urandom_range(0, 31));
    send(fdgl_pkg::ACT_RUN, 0, 0, 0, 0);
    wait_idle();

    // all gains at zero
    set_regs(0, 0, 0, 0, 2);
    send(fdgl_pkg::ACT_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < 3; i++) send(fdgl_pkg::ACT_LOAD_NODE, rand_pos(), rand_pos(), 0, 0);
    send(fdgl_pkg::ACT_LOAD_EDGE, 0, 0, 0, 2);
    send(fdgl_pkg::ACT_RUN, 0, 0, 0, 0);
    wait_idle();

    // random graphs, one setting per phase
    while (words_queued < 480) begin
      if (words_queued > 400) idling_on = 1'b0;
      set_regs(rand_gain(), $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 80),
               rand_gain(), rand_gain(), $urandom_range(1, 3));
      for (int g = 0; g < 3; g++) begin
        send(fdgl_pkg::ACT_CLEAR, 0, 0, 0, 0);
        n = $urandom_range(2, 6);
        e = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
          send(fdgl_pkg::ACT_LOAD_NODE, rand_pos(), rand_pos(), 0, 0);
        for (int i = 0; i < e; i++) begin
          if ($urandom_range(0, 7) == 0)
            send(fdgl_pkg::ACT_LOAD_EDGE, 0, 0, $urandom_range(0, 31), $urandom_range(0, 31));
          else
            send(fdgl_pkg::ACT_LOAD_EDGE, 0, 0, $urandom_range(0, n - 1),
                 $urandom_range(0, n - 1));
        end
        // noise: stray words, sometimes a broken graph
        if ($urandom_range(0, 4) == 0)
          send(fdgl_pkg::action_t'($urandom_range(0, 2)), rand_pos(), rand_pos(),
               $urandom_range(0, n - 1), $urandom_range(0, n - 1));
        send(fdgl_pkg::ACT_RUN, 0, 0, 0, 0);
        if ($urandom_range(0, 2) == 0) send(fdgl_pkg::ACT_RUN, 0, 0, 0, 0);
      end
      wait_idle();
    end

    wait_idle();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && final_positions.size() == 0) begin
      $display("force_directed_graph_layout verification clean");
    end else begin
      $display("force_directed_graph_layout verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fdgl_pkg.sv
design/fdgl_ram.sv
design/fdgl_div.sv
design/force_directed_graph_layout.sv
tb/force_directed_graph_layout_test.sv
